// ===== src/uks_pkg.sv =====
package uks_pkg;

	// stack geometry
	localparam int DEPTH = 64;
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FillW = $clog2(DEPTH + 1);

	// field widths
	localparam int ReqW = 2;
	localparam int KeyW = 16;
	localparam int ValW = 8;
	localparam int StatW = 2;
	localparam int CntW = 7;
	localparam int EntryW = KeyW + ValW;

	// presence map for allocate: bit c-1 marks key c, keys 1..DEPTH+1
	localparam int NumCand = DEPTH + 1;
	localparam int ChunkW = 8;
	localparam int ChunkBitW = $clog2(ChunkW);
	localparam int NumChunks = (NumCand + ChunkW - 1) / ChunkW;
	localparam int MapW = NumChunks * ChunkW;
	localparam int MapIdxW = $clog2(MapW);
	localparam int ChunkIdxW = (NumChunks > 1) ? $clog2(NumChunks) : 1;

	typedef enum logic [ReqW-1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_ALLOC = 2'd3
	} req_e_t;

	typedef enum logic [StatW-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DUP   = 2'd2,
		ST_EMPTY = 2'd3
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_TOPRD,
		S_SEARCH,
		S_DONE
	} state_e_t;

endpackage

// ===== src/uks_req_if.sv =====
interface uks_req_if;
	logic                          valid;
	logic                          ready;
	logic [uks_pkg::ReqW-1:0]      req_type;
	logic [uks_pkg::KeyW-1:0]      key;
	logic signed [uks_pkg::ValW-1:0] value;

	modport source (output valid, output req_type, output key, output value, input ready);
	modport sink (input valid, input req_type, input key, input value, output ready);
endinterface

// ===== src/uks_rsp_if.sv =====
interface uks_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [uks_pkg::StatW-1:0]     status;
	logic [uks_pkg::KeyW-1:0]      out_key;
	logic signed [uks_pkg::ValW-1:0] out_value;
	logic [uks_pkg::CntW-1:0]      count;

	modport source (output valid, output status, output out_key, output out_value,
		output count, input ready);
	modport sink (input valid, input status, input out_key, input out_value,
		input count, output ready);
endinterface

// ===== src/uks_ram.sv =====
module uks_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
	input  logic [Width-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
	output logic [Width-1:0]                           rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== src/unique_key_stack.sv =====
// unique_key_stack: bounded LIFO of (key, value) entries, DEPTH deep, in which
// every stored key is distinct. One request beat in gives exactly one result
// beat out, always carrying the entry count after the request. Push is refused
// with status full when the stack holds DEPTH entries (checked first), or with
// status duplicate when the key is already stored; pop and peek on an empty
// stack give status empty with zero key and value; allocate always gives
// status ok with the smallest key from 1 up that is not stored (at most
// DEPTH+1), echoes the value and stores nothing. Entries live in one
// single-port-read RAM, and the stored keys are checked one entry a cycle
// through its read port, so the time taken grows with the entry count: pop and
// peek read the top entry, push scans the stored
// entries and stops on a duplicate hit (no scan when full or empty); allocate
// scans all entries, then checks free keys one 8-key group a cycle (at most DEPTH/8+1
// groups). One request is in flight at a time; a finished result sits in the
// output register and only holds the block back if it has not been taken when
// the next result is ready. No clearing pass is needed after reset.
module unique_key_stack (
	input logic     clk,
	input logic     arst_n,
	uks_req_if.sink req,
	uks_rsp_if.source rsp
);
	import uks_pkg::*;

	// controller state
	state_e_t state_q, state_d;
	logic [FillW-1:0] fill_q, fill_next;
	logic [AddrW-1:0] scan_q;
	logic [ChunkIdxW-1:0] chunk_q;
	logic [MapW-1:0] map_q;

	// latched request and result in progress
	req_e_t req_type_q;
	logic [KeyW-1:0] req_key_q;
	logic signed [ValW-1:0] req_value_q;
	status_e_t res_status_q;
	logic [KeyW-1:0] res_key_q;
	logic signed [ValW-1:0] res_value_q;

	// output register
	logic rsp_valid_q;
	status_e_t rsp_status_q;
	logic [KeyW-1:0] rsp_key_q;
	logic signed [ValW-1:0] rsp_value_q;
	logic [CntW-1:0] rsp_count_q;

	// ram side
	logic ram_we, ram_re;
	logic [AddrW-1:0] ram_waddr, ram_raddr;
	logic [EntryW-1:0] ram_wdata, ram_rdata;
	logic [KeyW-1:0] rd_key;
	logic signed [ValW-1:0] rd_value;

	logic req_fire, out_free, done_fire;
	req_e_t in_type;
	logic fill_zero, fill_full, scan_last, scan_match;
	logic [ChunkW-1:0] chunk_bits;
	logic zero_found;
	logic [ChunkBitW-1:0] zero_pos;
	logic [KeyW-1:0] cand_key;
	logic [KeyW-1:0] mark_off;

	uks_ram #(
		.Width(EntryW),
		.Depth(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_key = ram_rdata[EntryW-1 -: KeyW];
	assign rd_value = signed'(ram_rdata[ValW-1:0]);

	assign in_type = req_e_t'(req.req_type);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req_fire = req.valid && req.ready;

	assign fill_zero = (fill_q == '0);
	assign fill_full = (fill_q == FillW'(DEPTH));
	// data on the ram output belongs to entry scan_q while scanning
	assign scan_last = (FillW'(scan_q) == fill_q - FillW'(1));
	assign scan_match = (rd_key == req_key_q);
	// key c is marked at bit c-1
	assign mark_off = rd_key - KeyW'(1);

	// free-key search, one group of eight keys a cycle, lowest clear bit wins
	assign chunk_bits = map_q[chunk_q*ChunkW +: ChunkW];
	always_comb begin
		zero_found = 1'b0;
		zero_pos = '0;
		for (int b = ChunkW - 1; b >= 0; b--) begin
			if (!chunk_bits[b]) begin
				zero_found = 1'b1;
				zero_pos = ChunkBitW'(b);
			end
		end
	end
	assign cand_key = KeyW'({chunk_q, zero_pos}) + KeyW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					case (in_type)
						REQ_PUSH:
							state_d = (fill_full || fill_zero) ? S_DONE : S_SCAN;
						REQ_POP, REQ_PEEK:
							state_d = fill_zero ? S_DONE : S_TOPRD;
						default:
							state_d = fill_zero ? S_SEARCH : S_SCAN;
					endcase
				end
			end
			S_SCAN: begin
				if (req_type_q == REQ_PUSH) begin
					if (scan_match || scan_last) begin
						state_d = S_DONE;
					end
				end else if (scan_last) begin
					state_d = S_SEARCH;
				end
			end
			S_TOPRD: state_d = S_DONE;
			S_SEARCH: begin
				if (zero_found) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		req.ready = 1'b0;
		ram_re = 1'b0;
		ram_raddr = '0;
		ram_we = 1'b0;
		ram_waddr = AddrW'(fill_q);
		ram_wdata = {req_key_q, req_value_q};
		done_fire = 1'b0;
		fill_next = fill_q;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				ram_re = 1'b1;
				// pop/peek read the top, push/allocate start the scan at entry 0
				if (in_type == REQ_POP || in_type == REQ_PEEK) begin
					ram_raddr = AddrW'(fill_q - FillW'(1));
				end
			end
			S_SCAN: begin
				ram_re = 1'b1;
				ram_raddr = scan_q + AddrW'(1);
			end
			S_DONE: begin
				done_fire = out_free;
				if (res_status_q == ST_OK) begin
					if (req_type_q == REQ_PUSH) begin
						fill_next = fill_q + FillW'(1);
						ram_we = out_free;
					end else if (req_type_q == REQ_POP) begin
						fill_next = fill_q - FillW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (done_fire) begin
				fill_q <= fill_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// request, scan and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_type_q <= in_type;
				req_key_q <= req.key;
				req_value_q <= req.value;
				scan_q <= '0;
				chunk_q <= '0;
				map_q <= '0;
				res_key_q <= '0;
				res_value_q <= (in_type == REQ_ALLOC) ? req.value : '0;
				res_status_q <= ST_OK;
				if (in_type == REQ_PUSH && fill_full) begin
					res_status_q <= ST_FULL;
				end else if ((in_type == REQ_POP || in_type == REQ_PEEK) && fill_zero) begin
					res_status_q <= ST_EMPTY;
				end
			end
			S_SCAN: begin
				scan_q <= scan_q + AddrW'(1);
				if (req_type_q == REQ_PUSH) begin
					if (scan_match) begin
						res_status_q <= ST_DUP;
					end
				end else if (rd_key != '0 && mark_off < KeyW'(NumCand)) begin
					map_q[MapIdxW'(mark_off)] <= 1'b1;
				end
			end
			S_TOPRD: begin
				res_key_q <= rd_key;
				res_value_q <= rd_value;
			end
			S_SEARCH: begin
				if (zero_found) begin
					res_key_q <= cand_key;
				end else begin
					chunk_q <= chunk_q + ChunkIdxW'(1);
				end
			end
			default: ;
		endcase
		if (done_fire) begin
			rsp_status_q <= res_status_q;
			rsp_key_q <= res_key_q;
			rsp_value_q <= res_value_q;
			rsp_count_q <= CntW'(fill_next);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.out_key = rsp_key_q;
	assign rsp.out_value = rsp_value_q;
	assign rsp.count = rsp_count_q;

`ifndef ASSERT_OFF
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FillW'(DEPTH))
		else $error("fill count beyond depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (fill_q < FillW'(DEPTH)) && (req_type_q == REQ_PUSH))
		else $error("entry written without room or not by a push");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.count == CntW'(DEPTH))
		else $error("full status with stack not full");

	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |-> chunk_q <= ChunkIdxW'(NumChunks - 1))
		else $error("free-key search ran past the map");

	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req.ready)
		else $error("second request taken while one is in flight");
`endif
endmodule
